// ===== design/epl2n_pkg.sv =====
// ----------------------------------------------------------------------------
// epl2n_pkg
// Shared types and constants for the pooled embedding L2 normalizer.
// ----------------------------------------------------------------------------
package epl2n_pkg;

  // Default number of stored vector elements.
  localparam int EMBED_DIM_MAX_DEF = 1024;

  // Fixed field widths.
  localparam int ACC_W     = 48;
  localparam int VAL_W     = 32;
  localparam int OUT_W     = 32;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  // Depth of the request queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POOLING_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMBED_DIM    = 1'b1;

  // Reset value of the embed_dim register.
  localparam logic [CFG_W-1:0] EMBED_DIM_RST = 11'd1024;

  // Commands.
  localparam logic CMD_ELEM = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  // Input request.
  typedef struct packed {
    logic                    command;
    logic signed [VAL_W-1:0] value;
    logic                    end_of_sequence;
  } in_req_t;

  // Output result.
  typedef struct packed {
    logic signed [OUT_W-1:0] normalized_value;
    logic                    last_element;
    logic [1:0]              status;
  } out_res_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic    valid;
    in_req_t req;
  } q_head_t;

  // Sequencer states of the back end.
  typedef enum logic [17:0] {
    S_CLR    = 18'h00001,
    S_IDLE   = 18'h00002,
    S_E_RD   = 18'h00004,
    S_E_WR   = 18'h00008,
    S_MX_RD  = 18'h00010,
    S_MX_CK  = 18'h00020,
    S_LEN    = 18'h00040,
    S_SQ_RD  = 18'h00080,
    S_SQ_B   = 18'h00100,
    S_SQ_M   = 18'h00200,
    S_SQ_A   = 18'h00400,
    S_KSH    = 18'h00800,
    S_SQRT   = 18'h01000,
    S_DIV    = 18'h02000,
    S_RD_RD  = 18'h04000,
    S_RD_B   = 18'h08000,
    S_RD_M   = 18'h10000,
    S_RD_OUT = 18'h20000
  } state_t;

endpackage

// ===== design/epl2n_ram.sv =====
// ----------------------------------------------------------------------------
// epl2n_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module epl2n_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/epl2n_front.sv =====
// ----------------------------------------------------------------------------
// epl2n_front
// Request intake: accepts requests and holds them in a short queue.
// ----------------------------------------------------------------------------
module epl2n_front #(
  parameter int DEPTH = epl2n_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  epl2n_pkg::in_req_t in_data,
  input  logic               pop,
  output epl2n_pkg::q_head_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  epl2n_pkg::in_req_t q_r [DEPTH];
  logic [PW-1:0] wptr_r;
  logic [PW-1:0] rptr_r;
  logic [CW-1:0] cnt_r;
  logic          push;
  logic          do_pop;

  assign busy   = (cnt_r == CW'(DEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (cnt_r != '0);

  assign head.valid = (cnt_r != '0);
  assign head.req   = q_r[rptr_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= in_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(do_pop);
    end
  end

endmodule

// ===== design/epl2n_back.sv =====
// ----------------------------------------------------------------------------
// epl2n_back
// Execution sequencer: accumulates elements, computes the inverse norm with
// iterative square root and divider, and produces normalized elements.
// ----------------------------------------------------------------------------
module epl2n_back #(
  parameter int EMBED_DIM_MAX = epl2n_pkg::EMBED_DIM_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [epl2n_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [epl2n_pkg::CFG_W-1:0]         cfg_wdata,
  input  epl2n_pkg::q_head_t                  head,
  output logic                                pop,
  output logic                                out_valid,
  output epl2n_pkg::out_res_t                 out_data
);

  localparam int AW   = (EMBED_DIM_MAX > 1) ? $clog2(EMBED_DIM_MAX) : 1;
  localparam int DW   = $clog2(EMBED_DIM_MAX + 1);
  localparam int SUMW = 63 + AW;
  localparam int KW   = $clog2(SUMW);
  localparam int ACCW = epl2n_pkg::ACC_W;

  epl2n_pkg::state_t state_r;

  // Configuration.
  logic                        pool_last_r;
  logic [epl2n_pkg::CFG_W-1:0] embed_dim_r;

  // Architectural state.
  logic [AW-1:0] eidx_r;
  logic [AW-1:0] ridx_r;
  logic          ready_r;
  logic          zero_r;
  logic [31:0]   inv_r;
  logic [KW-1:0] k_r;
  logic          shl_r;
  logic [5:0]    sh_r;

  // Work registers.
  epl2n_pkg::in_req_t item_r;
  logic               elem_after_clr_r;
  logic [AW-1:0]      cnt_r;
  logic [ACCW-1:0]    max_r;
  logic [ACCW-1:0]    lensh_r;
  logic [5:0]         len_r;
  logic [30:0]        b_r;
  logic               neg_r;
  logic [61:0]        sq_r;
  logic [SUMW-1:0]    sum_r;
  logic [63:0]        x_r;
  logic [63:0]        res_r;
  logic [63:0]        bit_r;
  logic [31:0]        dvs_r;
  logic [61:0]        num_r;
  logic [32:0]        rem_r;
  logic [31:0]        q_r;
  logic [5:0]         dcnt_r;
  logic [62:0]        p_r;

  // RAM port.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [ACCW-1:0] ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [ACCW-1:0] ram_rdata;

  epl2n_ram #(
    .WIDTH(ACCW),
    .DEPTH(EMBED_DIM_MAX),
    .AW   (AW)
  ) u_acc (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Effective vector length and its last index.
  logic [DW-1:0] d_use;
  logic [AW-1:0] d_last;
  always_comb begin
    if (embed_dim_r == '0) begin
      d_use = DW'(1);
    end else if (32'(embed_dim_r) > 32'(EMBED_DIM_MAX)) begin
      d_use = DW'(EMBED_DIM_MAX);
    end else begin
      d_use = DW'(embed_dim_r);
    end
    d_last = AW'(d_use - 1'b1);
  end

  logic e_wrap;
  logic r_last;
  assign e_wrap = (32'(eidx_r) + 32'd1) >= 32'(d_use);
  assign r_last = (32'(ridx_r) + 32'd1) >= 32'(d_use);

  // Magnitude of the stored entry and its block-scaled form.
  logic [ACCW-1:0] rd_mag;
  logic [63:0]     rd_shift;
  logic [30:0]     rd_scaled;
  always_comb begin
    rd_mag    = ram_rdata[ACCW-1] ? (~ram_rdata + 1'b1) : ram_rdata;
    rd_shift  = shl_r ? (64'(rd_mag) << sh_r) : (64'(rd_mag) >> sh_r);
    rd_scaled = rd_shift[30:0];
  end

  // Saturating accumulate.
  logic signed [ACCW:0]   acc_sum;
  logic [ACCW-1:0]        acc_new;
  always_comb begin
    acc_sum = $signed({ram_rdata[ACCW-1], ram_rdata})
            + (ACCW+1)'($signed(item_r.value));
    if (acc_sum[ACCW:ACCW-1] == 2'b01) begin
      acc_new = {1'b0, {(ACCW-1){1'b1}}};
    end else if (acc_sum[ACCW:ACCW-1] == 2'b10) begin
      acc_new = {1'b1, {(ACCW-1){1'b0}}};
    end else begin
      acc_new = acc_sum[ACCW-1:0];
    end
  end

  // Square root step.
  logic [63:0] sq_trial;
  assign sq_trial = res_r + bit_r;

  // Divider step.
  logic [32:0] dv_shift;
  assign dv_shift = {rem_r[31:0], num_r[61]};

  // Rounded output element.
  logic [5:0]  tot;
  logic [63:0] rnd;
  logic [63:0] y_full;
  logic [31:0] y_mag;
  logic [31:0] y_out;
  always_comb begin
    tot    = 6'd31 + 6'(k_r);
    rnd    = 64'(p_r) + (64'd1 << (tot - 6'd1));
    y_full = rnd >> tot;
    y_mag  = (y_full > 64'd1073741824) ? 32'd1073741824 : y_full[31:0];
    y_out  = neg_r ? (~y_mag + 1'b1) : y_mag;
  end

  // RAM controls by state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = '0;
    ram_raddr = cnt_r;
    case (state_r)
      epl2n_pkg::S_CLR: begin
        ram_we = 1'b1;
      end
      epl2n_pkg::S_E_RD: begin
        ram_raddr = eidx_r;
      end
      epl2n_pkg::S_E_WR: begin
        ram_we    = 1'b1;
        ram_waddr = eidx_r;
        ram_wdata = pool_last_r ? ACCW'($signed(item_r.value)) : acc_new;
      end
      epl2n_pkg::S_RD_RD: begin
        ram_raddr = ridx_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign pop = (state_r == epl2n_pkg::S_IDLE) && head.valid;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_last_r <= 1'b0;
      embed_dim_r <= epl2n_pkg::EMBED_DIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        epl2n_pkg::CFG_POOLING_MODE: pool_last_r <= cfg_wdata[0];
        epl2n_pkg::CFG_EMBED_DIM:    embed_dim_r <= cfg_wdata;
        default:                     pool_last_r <= pool_last_r;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    case (state_r)
      epl2n_pkg::S_IDLE: begin
        if (head.valid) begin
          item_r <= head.req;
        end
      end
      epl2n_pkg::S_MX_CK: begin
        if (rd_mag > max_r) begin
          lensh_r <= rd_mag;
        end else begin
          lensh_r <= max_r;
        end
        len_r <= '0;
      end
      epl2n_pkg::S_LEN: begin
        if (lensh_r != '0) begin
          lensh_r <= lensh_r >> 1;
          len_r   <= len_r + 1'b1;
        end
      end
      epl2n_pkg::S_SQ_B: begin
        b_r <= rd_scaled;
      end
      epl2n_pkg::S_SQ_M: begin
        sq_r <= 62'(b_r * b_r);
      end
      epl2n_pkg::S_RD_B: begin
        b_r   <= rd_scaled;
        neg_r <= ram_rdata[ACCW-1];
      end
      epl2n_pkg::S_RD_M: begin
        p_r <= 63'(b_r * inv_r);
      end
      default: begin
        b_r <= b_r;
      end
    endcase
  end

  // Sequencer and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= epl2n_pkg::S_CLR;
      elem_after_clr_r <= 1'b0;
      cnt_r            <= '0;
      eidx_r           <= '0;
      ridx_r           <= '0;
      ready_r          <= 1'b0;
      zero_r           <= 1'b0;
      inv_r            <= '0;
      k_r              <= '0;
      shl_r            <= 1'b0;
      sh_r             <= '0;
      max_r            <= '0;
      sum_r            <= '0;
      x_r              <= '0;
      res_r            <= '0;
      bit_r            <= '0;
      dvs_r            <= '0;
      num_r            <= '0;
      rem_r            <= '0;
      q_r              <= '0;
      dcnt_r           <= '0;
      out_valid        <= 1'b0;
      out_data         <= '0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        // Zero the accumulator, one entry per cycle.
        epl2n_pkg::S_CLR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == AW'(EMBED_DIM_MAX - 1)) begin
            cnt_r            <= '0;
            elem_after_clr_r <= 1'b0;
            state_r          <= elem_after_clr_r ? epl2n_pkg::S_E_RD : epl2n_pkg::S_IDLE;
          end
        end
        // Take the next request from the queue.
        epl2n_pkg::S_IDLE: begin
          if (head.valid) begin
            if (head.req.command == epl2n_pkg::CMD_ELEM) begin
              if (ready_r) begin
                ready_r          <= 1'b0;
                zero_r           <= 1'b0;
                ridx_r           <= '0;
                cnt_r            <= '0;
                elem_after_clr_r <= 1'b1;
                state_r          <= epl2n_pkg::S_CLR;
              end else begin
                state_r <= epl2n_pkg::S_E_RD;
              end
            end else if (!ready_r) begin
              out_valid <= 1'b1;
              out_data  <= '{normalized_value: '0, last_element: 1'b0,
                             status: epl2n_pkg::ST_NONE};
            end else if (zero_r) begin
              out_valid <= 1'b1;
              out_data  <= '{normalized_value: '0, last_element: r_last,
                             status: epl2n_pkg::ST_ZERO};
              ridx_r    <= r_last ? '0 : ridx_r + 1'b1;
            end else begin
              state_r <= epl2n_pkg::S_RD_RD;
            end
          end
        end
        epl2n_pkg::S_E_RD: begin
          state_r <= epl2n_pkg::S_E_WR;
        end
        // Store the element and advance the element index.
        epl2n_pkg::S_E_WR: begin
          if (e_wrap) begin
            eidx_r <= '0;
            if (item_r.end_of_sequence) begin
              cnt_r   <= '0;
              max_r   <= '0;
              state_r <= epl2n_pkg::S_MX_RD;
            end else begin
              state_r <= epl2n_pkg::S_IDLE;
            end
          end else begin
            eidx_r  <= eidx_r + 1'b1;
            state_r <= epl2n_pkg::S_IDLE;
          end
        end
        // Largest magnitude pass.
        epl2n_pkg::S_MX_RD: begin
          state_r <= epl2n_pkg::S_MX_CK;
        end
        epl2n_pkg::S_MX_CK: begin
          if (rd_mag > max_r) begin
            max_r <= rd_mag;
          end
          if (cnt_r == d_last) begin
            cnt_r <= '0;
            if (max_r == '0 && rd_mag == '0) begin
              zero_r  <= 1'b1;
              ready_r <= 1'b1;
              ridx_r  <= '0;
              inv_r   <= '0;
              k_r     <= '0;
              shl_r   <= 1'b0;
              sh_r    <= '0;
              state_r <= epl2n_pkg::S_IDLE;
            end else begin
              state_r <= epl2n_pkg::S_LEN;
            end
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= epl2n_pkg::S_MX_RD;
          end
        end
        // Bit length of the largest magnitude, one bit per cycle.
        epl2n_pkg::S_LEN: begin
          if (lensh_r == '0) begin
            if (len_r >= 6'd31) begin
              shl_r <= 1'b0;
              sh_r  <= len_r - 6'd31;
            end else begin
              shl_r <= 1'b1;
              sh_r  <= 6'd31 - len_r;
            end
            sum_r   <= '0;
            cnt_r   <= '0;
            state_r <= epl2n_pkg::S_SQ_RD;
          end
        end
        // Sum of squares pass.
        epl2n_pkg::S_SQ_RD: begin
          state_r <= epl2n_pkg::S_SQ_B;
        end
        epl2n_pkg::S_SQ_B: begin
          state_r <= epl2n_pkg::S_SQ_M;
        end
        epl2n_pkg::S_SQ_M: begin
          state_r <= epl2n_pkg::S_SQ_A;
        end
        epl2n_pkg::S_SQ_A: begin
          sum_r <= sum_r + SUMW'(sq_r);
          if (cnt_r == d_last) begin
            cnt_r   <= '0;
            k_r     <= '0;
            state_r <= epl2n_pkg::S_KSH;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= epl2n_pkg::S_SQ_RD;
          end
        end
        // Bring the sum below 2^62 in steps of two bits.
        epl2n_pkg::S_KSH: begin
          if (sum_r >= (SUMW'(1) << 62)) begin
            sum_r <= sum_r >> 2;
            k_r   <= k_r + 1'b1;
          end else begin
            x_r     <= 64'(sum_r);
            res_r   <= '0;
            bit_r   <= 64'd1 << 62;
            state_r <= epl2n_pkg::S_SQRT;
          end
        end
        // Integer square root, two radicand bits per cycle.
        epl2n_pkg::S_SQRT: begin
          if (bit_r != '0) begin
            if (x_r >= sq_trial) begin
              x_r   <= x_r - sq_trial;
              res_r <= (res_r >> 1) + bit_r;
            end else begin
              res_r <= res_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end else begin
            dvs_r   <= (res_r == '0) ? 32'd1 : res_r[31:0];
            num_r   <= (62'd1 << 61) + 62'(((res_r == '0) ? 64'd1 : res_r) >> 1);
            rem_r   <= '0;
            q_r     <= '0;
            dcnt_r  <= '0;
            state_r <= epl2n_pkg::S_DIV;
          end
        end
        // Restoring divide, one quotient bit per cycle.
        epl2n_pkg::S_DIV: begin
          num_r <= num_r << 1;
          if (dv_shift >= 33'(dvs_r)) begin
            rem_r <= dv_shift - 33'(dvs_r);
            q_r   <= {q_r[30:0], 1'b1};
          end else begin
            rem_r <= dv_shift;
            q_r   <= {q_r[30:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == 6'd61) begin
            state_r <= epl2n_pkg::S_IDLE;
            ready_r <= 1'b1;
            zero_r  <= 1'b0;
            ridx_r  <= '0;
          end
        end
        // Normalized read of one element.
        epl2n_pkg::S_RD_RD: begin
          state_r <= epl2n_pkg::S_RD_B;
        end
        epl2n_pkg::S_RD_B: begin
          state_r <= epl2n_pkg::S_RD_M;
        end
        epl2n_pkg::S_RD_M: begin
          state_r <= epl2n_pkg::S_RD_OUT;
        end
        epl2n_pkg::S_RD_OUT: begin
          out_valid <= 1'b1;
          out_data  <= '{normalized_value: y_out, last_element: r_last,
                         status: epl2n_pkg::ST_OK};
          ridx_r    <= r_last ? '0 : ridx_r + 1'b1;
          state_r   <= epl2n_pkg::S_IDLE;
        end
        default: begin
          state_r <= epl2n_pkg::S_IDLE;
        end
      endcase
      // The full quotient is written to inv_r on the last divide step.
      if (state_r == epl2n_pkg::S_DIV && dcnt_r == 6'd61) begin
        inv_r <= (dv_shift >= 33'(dvs_r)) ? {q_r[30:0], 1'b1} : {q_r[30:0], 1'b0};
      end
    end
  end

endmodule

// ===== design/embedding_pool_l2_normalize.sv =====
// ----------------------------------------------------------------------------
// embedding_pool_l2_normalize
// Pooled embedding vector with L2 normalization in fixed point.
// ----------------------------------------------------------------------------
// Requests enter on in_data when start is high and busy is low. A request
// with command 0 stores one Q16.16 element (summed in mean mode, overwritten
// in last mode); command 1 reads the next normalized Q1.30 element, which
// appears on out_data for one cycle with out_valid high. The receiver cannot
// stall; results are never held back.
// A two-entry request queue sits in front of the sequencer, so busy rises
// only when that queue is full.
// An element passes through a RAM read state and a write-back state; a read
// goes through RAM read, scale, multiply and output states, or is answered
// from idle when no vector is ready or the vector is zero. The element that
// ends a sequence starts the norm pass: a max-magnitude scan (which ends the
// pass for an all-zero vector), its bit length, a sum-of-squares scan, sum
// scaling, then the square root and the divide. The first element after a
// finished vector first clears all EMBED_DIM_MAX accumulator entries. After
// reset the same pass runs; configuration writes are taken during it.
// ----------------------------------------------------------------------------
module embedding_pool_l2_normalize #(
  parameter int EMBED_DIM_MAX = epl2n_pkg::EMBED_DIM_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  epl2n_pkg::in_req_t              in_data,
  output logic                            out_valid,
  output epl2n_pkg::out_res_t             out_data,
  input  logic                            cfg_we,
  input  logic [epl2n_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [epl2n_pkg::CFG_W-1:0]     cfg_wdata
);

  epl2n_pkg::q_head_t head;
  logic               pop;

  // Request intake and queue.
  epl2n_front #(
    .DEPTH(epl2n_pkg::QUEUE_DEPTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .in_data(in_data),
    .pop    (pop),
    .head   (head)
  );

  // Sequencer and arithmetic.
  epl2n_back #(
    .EMBED_DIM_MAX(EMBED_DIM_MAX)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule
